@@ hdl/rbbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbbr_pkg
// Shared types and constants of the ring buffer burst read unit.
// ----------------------------------------------------------------------------
package rbbr_pkg;

    localparam int DEPTH_DEFAULT = 64;   // bytes of storage
    localparam int LEN_RESET     = 64;   // used length after reset
    localparam int LEN_W         = 7;    // used length / fill level width
    localparam int RUN_W         = 7;    // holds MAX_RUN
    localparam int MAX_RUN       = 64;   // longest run of read results
    localparam int QUEUE_DEPTH   = 2;    // command queue entries

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_READ_REFUSED = 2'd1;
    localparam logic [1:0] STATUS_WRITE_FULL   = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_READ      = 2'd1,
        CMD_READ_ZERO = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  write_byte;
        logic [7:0]  read_count;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       read_byte;
        logic             last;
        logic [LEN_W-1:0] fill_level;
        logic             is_full;
        logic             is_empty;
    } result_t;

endpackage

@@ hdl/rbbr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbbr_front
// Accepts input items, sorts them into write, read and zero-count read
// commands and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module rbbr_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,    // write_byte[7:0], read_count[15:8]
    input  logic [0:0]    s_tuser,    // op[0]
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output rbbr_pkg::cmd_t cmd
);

    localparam int QD  = rbbr_pkg::QUEUE_DEPTH;
    localparam int QPW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    rbbr_pkg::cmd_t   queue_reg [QD];
    logic [QPW-1:0]   wptr_reg, wptr_next;
    logic [QPW-1:0]   rptr_reg, rptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    rbbr_pkg::cmd_t   in_cmd;
    logic             push, pop;

    always_comb begin
        in_cmd.write_byte = s_tdata[7:0];
        in_cmd.read_count = s_tdata[15:8];
        if (s_tuser[0] == rbbr_pkg::OP_READ) begin
            in_cmd.kind = (s_tdata[15:8] == 8'd0) ? rbbr_pkg::CMD_READ_ZERO
                                                   : rbbr_pkg::CMD_READ;
        end else begin
            in_cmd.kind = rbbr_pkg::CMD_WRITE;
        end
    end

    assign s_tready  = (count_reg != QCW'(QD));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == QPW'(QD - 1)) ? '0 : wptr_reg + QPW'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == QPW'(QD - 1)) ? '0 : rptr_reg + QPW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wptr_reg] <= in_cmd;
        end
    end

endmodule

@@ hdl/rbbr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbbr_back
// Carries out queued commands against the byte store and ring indices, holds
// the output register and runs reads one byte a cycle unless it is stalled.
// ----------------------------------------------------------------------------
module rbbr_back #(
    parameter int DEPTH = rbbr_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rbbr_pkg::LEN_W-1:0]    cfg_wr_data,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  rbbr_pkg::cmd_t                cmd,
    output logic                          res_valid,
    input  logic                          res_ready,
    output rbbr_pkg::result_t             res
);

    localparam int IW      = $clog2(DEPTH);
    localparam int CW      = ((IW > rbbr_pkg::LEN_W) ? IW : rbbr_pkg::LEN_W) + 1;
    localparam int RW      = rbbr_pkg::RUN_W;
    localparam int LEN_RST = (DEPTH < rbbr_pkg::LEN_RESET) ? DEPTH : rbbr_pkg::LEN_RESET;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [IW-1:0]     ri_reg, ri_next;
    logic [IW-1:0]     wi_reg, wi_next;
    logic              full_reg, full_next;
    logic [CW-1:0]     len_reg, len_next;
    logic [RW-1:0]     remain_reg, remain_next;
    logic              out_valid_reg, out_valid_next;
    rbbr_pkg::result_t out_reg, out_next;
    logic [7:0]        mem_q_reg;
    logic [7:0]        mem [DEPTH];

    logic              out_free;
    logic              mem_we;
    logic [CW-1:0]     fill_cur;
    logic [8:0]        run_len;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i,
                                              input logic [CW-1:0] len);
        logic [CW-1:0] n;
        n = CW'(i) + CW'(1);
        return (n >= len) ? '0 : n[IW-1:0];
    endfunction

    function automatic logic [CW-1:0] fill_of(input logic [IW-1:0] r,
                                              input logic [IW-1:0] w,
                                              input logic          f,
                                              input logic [CW-1:0] len);
        if (r == w && f) begin
            return len;
        end else if (w >= r) begin
            return CW'(w) - CW'(r);
        end
        return CW'(w) + len - CW'(r);
    endfunction

    function automatic rbbr_pkg::result_t make_res(input logic [1:0]    st,
                                                   input logic [7:0]    b,
                                                   input logic          lst,
                                                   input logic [IW-1:0] r,
                                                   input logic [IW-1:0] w,
                                                   input logic          f,
                                                   input logic [CW-1:0] len);
        rbbr_pkg::result_t o;
        logic [CW-1:0]     fl;
        fl           = fill_of(r, w, f, len);
        o.status     = st;
        o.read_byte  = b;
        o.last       = lst;
        o.fill_level = fl[rbbr_pkg::LEN_W-1:0];
        o.is_full    = (r == w) && f;
        o.is_empty   = (r == w) && !f;
        return o;
    endfunction

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign fill_cur  = fill_of(ri_reg, wi_reg, full_reg, len_reg);

    // clamp the request to the fill level and to the longest run
    always_comb begin
        logic [8:0] c;
        logic [8:0] f;
        c = {1'b0, cmd.read_count};
        f = 9'(fill_cur);
        run_len = (c < f) ? c : f;
        if (run_len > 9'(rbbr_pkg::MAX_RUN)) begin
            run_len = 9'(rbbr_pkg::MAX_RUN);
        end
    end

    always_comb begin
        state_next     = state_reg;
        ri_next        = ri_reg;
        wi_next        = wi_reg;
        full_next      = full_reg;
        len_next       = len_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    case (cmd.kind)
                        rbbr_pkg::CMD_WRITE: begin
                            out_valid_next = 1'b1;
                            if (ri_reg == wi_reg && full_reg) begin
                                out_next = make_res(rbbr_pkg::STATUS_WRITE_FULL, 8'd0, 1'b1,
                                                    ri_reg, wi_reg, full_reg, len_reg);
                            end else begin
                                mem_we    = 1'b1;
                                wi_next   = idx_inc(wi_reg, len_reg);
                                full_next = full_reg || (wi_next == ri_reg);
                                out_next  = make_res(rbbr_pkg::STATUS_OK, 8'd0, 1'b1,
                                                     ri_reg, wi_next, full_next, len_reg);
                            end
                        end
                        rbbr_pkg::CMD_READ: begin
                            if (fill_cur == '0) begin
                                out_valid_next = 1'b1;
                                out_next = make_res(rbbr_pkg::STATUS_READ_REFUSED, 8'd0,
                                                    1'b1, ri_reg, wi_reg, full_reg, len_reg);
                            end else begin
                                remain_next = run_len[RW-1:0];
                                state_next  = ST_RUN;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                            out_next = make_res(rbbr_pkg::STATUS_READ_REFUSED, 8'd0, 1'b1,
                                                ri_reg, wi_reg, full_reg, len_reg);
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    ri_next        = idx_inc(ri_reg, len_reg);
                    full_next      = 1'b0;
                    remain_next    = remain_reg - RW'(1);
                    out_valid_next = 1'b1;
                    out_next       = make_res(rbbr_pkg::STATUS_OK, mem_q_reg,
                                              remain_reg == RW'(1),
                                              ri_next, wi_reg, 1'b0, len_reg);
                    if (remain_reg == RW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a length write also empties the buffer
        if (cfg_wr_en) begin
            ri_next   = '0;
            wi_next   = '0;
            full_next = 1'b0;
            if (cfg_wr_data == '0) begin
                len_next = CW'(1);
            end else if (CW'(cfg_wr_data) > CW'(DEPTH)) begin
                len_next = CW'(DEPTH);
            end else begin
                len_next = CW'(cfg_wr_data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ri_reg        <= '0;
            wi_reg        <= '0;
            full_reg      <= 1'b0;
            len_reg       <= CW'(LEN_RST);
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ri_reg        <= ri_next;
            wi_reg        <= wi_next;
            full_reg      <= full_next;
            len_reg       <= len_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    // read data follows the next read index, so it is fresh when a run starts
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wi_reg] <= cmd.write_byte;
        end
        mem_q_reg <= mem[ri_next];
    end

endmodule

@@ hdl/ring_buffer_burst_read_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_burst_read_unit
// Byte ring buffer with a programmable used length and burst reads.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per operation; s_tuser selects write or read, a
//   write stores s_tdata[7:0], a read asks for s_tdata[15:8] bytes.
//   m_ channel: a write or a refused read gives one item; a read gives one
//   item per byte, clamped to the fill level and to 64, tlast on the final
//   one. Every item carries the fill level and full/empty flags after it.
//   cfg_wr_en/cfg_wr_data set the used length (0 acts as 1, above DEPTH as
//   DEPTH) and empty the buffer; write it only while the block is idle.
// Flow:
//   with nothing ahead of it, a write or refused read result passes the
//   command queue and then the output register; the first byte of a read
//   passes the command queue, the run state and the output register. A read
//   run gives one byte a cycle unless the output stalls, from the single read
//   port of the byte store. A two-entry command queue takes items meanwhile.
// Reset: indices zero, buffer empty, used length 64 (DEPTH if smaller);
//   the store contents are undefined until written.
// Stall: while m_tready is low the output register holds, the run pauses
//   and the command queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module ring_buffer_burst_read_unit #(
    parameter int DEPTH = rbbr_pkg::DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [rbbr_pkg::LEN_W-1:0] cfg_wr_data,   // used_length
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,       // write_byte[7:0], read_count[15:8]
    input  logic [0:0]                 s_tuser,       // op[0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,       // read_byte[7:0], fill_level[14:8],
                                                      // is_full[15], is_empty[16]
    output logic [1:0]                 m_tuser,       // status[1:0]
    output logic                       m_tlast
);

    logic              cmd_valid;
    logic              cmd_ready;
    rbbr_pkg::cmd_t    cmd;
    rbbr_pkg::result_t res;

    rbbr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    rbbr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {7'd0, res.is_empty, res.is_full, res.fill_level, res.read_byte};
    assign m_tuser = res.status;
    assign m_tlast = res.last;

`ifndef SYNTH
    // an empty buffer reports no bytes held
    a_empty_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[16] |-> m_tdata[14:8] == 7'd0)
        else $error("empty flag with nonzero fill level");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[15] && m_tdata[16]))
        else $error("full and empty flags both set");

    // refused operations end their item at once and carry no byte
    a_refused_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != rbbr_pkg::STATUS_OK |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("refused result without last or with data");

    // a run holds the back end until its last byte is in the output register
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !cmd_ready)
        else $error("command taken in the middle of a read run");
`endif

endmodule
